// File: rtl/cocs_pkg.sv
// cocs_pkg: shared types and constants for the convergent order candidate search
// depends on nothing; used by every rtl file through scoped names
package cocs_pkg;

  localparam int unsigned VALUE_WIDTH = 32;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_MODULUS = 1'b1;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] frac_numerator;
    logic [VALUE_WIDTH-1:0] frac_denominator;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] order_candidate;
    logic                   candidate_found;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GCD_CHK,
    ST_GCD_DIV,
    ST_RED_N,
    ST_RED_D,
    ST_CF_CHK,
    ST_CF_DIV,
    ST_CF_MUL,
    ST_CF_MUL2,
    ST_CF_TEST,
    ST_EXP_INIT,
    ST_EXP_RED,
    ST_EXP_STEP,
    ST_EXP_MUL,
    ST_EXP_MRED,
    ST_EXP_SQR,
    ST_EXP_SRED,
    ST_EXP_CHK,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;          // capture input item
    logic gcd_div_start; // gcd remainder a % b
    logic gcd_shift;     // a <= b, b <= r
    logic red_n_start;   // n / g
    logic red_n_take;
    logic red_d_start;   // d / g
    logic red_d_take;
    logic cf_div_start;  // num / den
    logic cf_mul1;       // quotient products, registered
    logic cf_mul2;       // recurrence update and cross products
    logic exp_init;      // acc, exponent, base reduce start
    logic exp_red_take;
    logic exp_mul_start; // acc * b mod m
    logic exp_mul_take;
    logic exp_sqr_start; // b * b mod m
    logic exp_sqr_take;
    logic exp_shift;
    logic found_set;
    logic done;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic d_zero;
    logic gcd_b_zero;
    logic den_zero;
    logic test_ok;       // distance, parity and modulus tests
    logic exp_zero;
    logic exp_lsb;
    logic acc_one;
  } stat_t;

endpackage

// File: rtl/cocs_divider.sv
// cocs_divider: restoring divider, one quotient bit per cycle, 64 by 32 bits
// depends on cocs_pkg
module cocs_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [2*cocs_pkg::VALUE_WIDTH-1:0]  dividend,
  input  logic [cocs_pkg::VALUE_WIDTH-1:0]    divisor,
  output logic                                busy,
  output logic [2*cocs_pkg::VALUE_WIDTH-1:0]  quotient,
  output logic [cocs_pkg::VALUE_WIDTH-1:0]    remainder
);

  localparam int unsigned W = cocs_pkg::VALUE_WIDTH;
  localparam int unsigned CW = $clog2(2 * W + 1);

  logic [CW-1:0]  count;
  logic [2*W-1:0] quo;
  logic [W:0]     rem;
  logic [W-1:0]   dsr;
  logic [W:0]     trial;
  logic [W:0]     shifted;

  always_comb begin
    shifted = {rem[W-1:0], quo[2*W-1]};
    trial = shifted - {1'b0, dsr};
  end

  // one shift and subtract per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CW'(2 * W);
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (count != '0) begin
      count <= count - 1'b1;
      if (!trial[W]) begin
        rem <= trial;
        quo <= {quo[2*W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[2*W-2:0], 1'b0};
      end
    end
  end

  assign busy = (count != '0);
  assign quotient = quo;
  assign remainder = rem[W-1:0];

endmodule

// File: rtl/cocs_datapath.sv
// cocs_datapath: operand registers, shared divider, multipliers and tests
// depends on cocs_pkg and cocs_divider
module cocs_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  cocs_pkg::in_item_t               item,
  input  logic [cocs_pkg::VALUE_WIDTH-1:0] base_value,
  input  logic [cocs_pkg::VALUE_WIDTH-1:0] modulus_value,
  input  cocs_pkg::ctrl_t                  ctrl,
  output cocs_pkg::stat_t                  stat,
  output cocs_pkg::out_item_t              result
);

  localparam int unsigned W = cocs_pkg::VALUE_WIDTH;

  logic [W-1:0] n, d, ga, gb, num, den;
  logic [W-1:0] h, hp, k, kp;
  logic [W-1:0] m, b, acc, e;
  logic [2*W-1:0] ah, ak, lhs, rhs;
  logic         found;
  logic [W-1:0] found_k;

  logic           div_start;
  logic           div_busy;
  logic [2*W-1:0] div_dividend;
  logic [W-1:0]   div_divisor;
  logic [2*W-1:0] div_q;
  logic [W-1:0]   div_r;
  logic [2*W-1:0] diff;

  // divider operand selection
  always_comb begin
    div_start = ctrl.gcd_div_start | ctrl.red_n_start | ctrl.red_d_start |
                ctrl.cf_div_start | ctrl.exp_init | ctrl.exp_mul_start |
                ctrl.exp_sqr_start;
    div_dividend = {W'(0), ga};
    div_divisor = gb;
    if (ctrl.red_n_start) begin
      div_dividend = {W'(0), n};
      div_divisor = ga;
    end else if (ctrl.red_d_start) begin
      div_dividend = {W'(0), d};
      div_divisor = ga;
    end else if (ctrl.cf_div_start) begin
      div_dividend = {W'(0), num};
      div_divisor = den;
    end else if (ctrl.exp_init) begin
      div_dividend = {W'(0), base_value};
      div_divisor = modulus_value;
    end else if (ctrl.exp_mul_start) begin
      div_dividend = acc * b;
      div_divisor = m;
    end else if (ctrl.exp_sqr_start) begin
      div_dividend = b * b;
      div_divisor = m;
    end
  end

  cocs_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign diff = (lhs >= rhs) ? (lhs - rhs) : (rhs - lhs);

  // operand and recurrence registers
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else begin
      if (ctrl.load) begin
        n <= item.frac_numerator;
        d <= item.frac_denominator;
        ga <= item.frac_numerator;
        gb <= item.frac_denominator;
        found <= 1'b0;
        found_k <= '0;
        m <= modulus_value;
      end
      if (ctrl.gcd_shift) begin
        ga <= gb;
        gb <= div_r;
      end
      if (ctrl.red_n_take) begin
        n <= div_q[W-1:0];
        num <= div_q[W-1:0];
      end
      if (ctrl.red_d_take) begin
        d <= div_q[W-1:0];
        den <= div_q[W-1:0];
        h <= W'(1);
        hp <= '0;
        k <= '0;
        kp <= W'(1);
      end
      if (ctrl.cf_mul1) begin
        ah <= div_q[W-1:0] * h;
        ak <= div_q[W-1:0] * k;
        num <= den;
        den <= div_r;
      end
      if (ctrl.cf_mul2) begin
        h <= ah[W-1:0] + hp;
        hp <= h;
        k <= ak[W-1:0] + kp;
        kp <= k;
        lhs <= n * (ak[W-1:0] + kp);
        rhs <= (ah[W-1:0] + hp) * d;
      end
      if (ctrl.exp_init) begin
        acc <= W'(1);
        e <= k;
      end
      if (ctrl.exp_red_take | ctrl.exp_sqr_take) begin
        b <= div_r;
      end
      if (ctrl.exp_mul_take) begin
        acc <= div_r;
      end
      if (ctrl.exp_shift) begin
        e <= e >> 1;
      end
      if (ctrl.found_set) begin
        found <= 1'b1;
        found_k <= k;
      end
    end
  end

  // status back to the controller
  always_comb begin
    stat.div_busy = div_busy;
    stat.d_zero = (d == '0);
    stat.gcd_b_zero = (gb == '0);
    stat.den_zero = (den == '0);
    stat.test_ok = ({diff[2*W-2:0], 1'b0} < {W'(0), k}) && !diff[2*W-1] &&
                   !k[0] && (m >= W'(2));
    stat.exp_zero = (e == '0);
    stat.exp_lsb = e[0];
    stat.acc_one = (acc == W'(1));
  end

  assign result.order_candidate = found_k;
  assign result.candidate_found = found;

endmodule

// File: rtl/cocs_controller.sv
// cocs_controller: sequencer for gcd, continued fraction and power test
// depends on cocs_pkg
module cocs_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  cocs_pkg::stat_t stat,
  output logic            busy,
  output cocs_pkg::ctrl_t ctrl
);

  cocs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cocs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cocs_pkg::ST_IDLE: if (start) state_next = cocs_pkg::ST_GCD_CHK;
      cocs_pkg::ST_GCD_CHK: begin
        if (stat.d_zero) state_next = cocs_pkg::ST_DONE;
        else if (stat.gcd_b_zero) state_next = cocs_pkg::ST_RED_N;
        else state_next = cocs_pkg::ST_GCD_DIV;
      end
      cocs_pkg::ST_GCD_DIV: if (!stat.div_busy) state_next = cocs_pkg::ST_GCD_CHK;
      cocs_pkg::ST_RED_N: if (!stat.div_busy) state_next = cocs_pkg::ST_RED_D;
      cocs_pkg::ST_RED_D: if (!stat.div_busy) state_next = cocs_pkg::ST_CF_CHK;
      cocs_pkg::ST_CF_CHK: begin
        if (stat.den_zero) state_next = cocs_pkg::ST_DONE;
        else state_next = cocs_pkg::ST_CF_DIV;
      end
      cocs_pkg::ST_CF_DIV: if (!stat.div_busy) state_next = cocs_pkg::ST_CF_MUL;
      cocs_pkg::ST_CF_MUL: state_next = cocs_pkg::ST_CF_MUL2;
      cocs_pkg::ST_CF_MUL2: state_next = cocs_pkg::ST_CF_TEST;
      cocs_pkg::ST_CF_TEST: begin
        if (stat.test_ok) state_next = cocs_pkg::ST_EXP_INIT;
        else state_next = cocs_pkg::ST_CF_CHK;
      end
      cocs_pkg::ST_EXP_INIT: state_next = cocs_pkg::ST_EXP_RED;
      cocs_pkg::ST_EXP_RED: if (!stat.div_busy) state_next = cocs_pkg::ST_EXP_STEP;
      cocs_pkg::ST_EXP_STEP: begin
        if (stat.exp_zero) state_next = cocs_pkg::ST_EXP_CHK;
        else if (stat.exp_lsb) state_next = cocs_pkg::ST_EXP_MUL;
        else state_next = cocs_pkg::ST_EXP_SQR;
      end
      cocs_pkg::ST_EXP_MUL: state_next = cocs_pkg::ST_EXP_MRED;
      cocs_pkg::ST_EXP_MRED: if (!stat.div_busy) state_next = cocs_pkg::ST_EXP_SQR;
      cocs_pkg::ST_EXP_SQR: state_next = cocs_pkg::ST_EXP_SRED;
      cocs_pkg::ST_EXP_SRED: if (!stat.div_busy) state_next = cocs_pkg::ST_EXP_STEP;
      cocs_pkg::ST_EXP_CHK: begin
        if (stat.acc_one) state_next = cocs_pkg::ST_DONE;
        else state_next = cocs_pkg::ST_CF_CHK;
      end
      cocs_pkg::ST_DONE: state_next = cocs_pkg::ST_IDLE;
      default: state_next = cocs_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctrl = '0;
    case (state)
      cocs_pkg::ST_IDLE: ctrl.load = start;
      cocs_pkg::ST_GCD_CHK: begin
        ctrl.gcd_div_start = !stat.d_zero && !stat.gcd_b_zero;
        ctrl.red_n_start = !stat.d_zero && stat.gcd_b_zero;
      end
      cocs_pkg::ST_GCD_DIV: ctrl.gcd_shift = !stat.div_busy;
      cocs_pkg::ST_RED_N: begin
        ctrl.red_n_take = !stat.div_busy;
        ctrl.red_d_start = !stat.div_busy;
      end
      cocs_pkg::ST_RED_D: ctrl.red_d_take = !stat.div_busy;
      cocs_pkg::ST_CF_CHK: ctrl.cf_div_start = !stat.den_zero;
      cocs_pkg::ST_CF_DIV: ctrl.cf_mul1 = !stat.div_busy;
      cocs_pkg::ST_CF_MUL: ctrl.cf_mul2 = 1'b1;
      cocs_pkg::ST_EXP_INIT: ctrl.exp_init = 1'b1;
      cocs_pkg::ST_EXP_RED: ctrl.exp_red_take = !stat.div_busy;
      cocs_pkg::ST_EXP_MUL: ctrl.exp_mul_start = 1'b1;
      cocs_pkg::ST_EXP_MRED: ctrl.exp_mul_take = !stat.div_busy;
      cocs_pkg::ST_EXP_SQR: ctrl.exp_sqr_start = 1'b1;
      cocs_pkg::ST_EXP_SRED: begin
        ctrl.exp_sqr_take = !stat.div_busy;
        ctrl.exp_shift = !stat.div_busy;
      end
      cocs_pkg::ST_EXP_CHK: ctrl.found_set = stat.acc_one;
      cocs_pkg::ST_DONE: ctrl.done = 1'b1;
      default: ctrl = '0;
    endcase
  end

  assign busy = (state != cocs_pkg::ST_IDLE);

endmodule

// File: rtl/convergent_order_candidate_search.sv
// convergent_order_candidate_search: top level, config registers and result strobe
// depends on cocs_pkg, cocs_controller, cocs_datapath
//
// channel   signals                               direction
// start     start, busy, item                     in
// result    result_valid, result                  out
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  in
//
// one item at a time; busy stays high from acceptance until the result strobe.
// each division (gcd step, reduction, quotient, modular reduction) runs in one
// shared restoring divider; a convergent that reaches the power test adds up to
// 65 modular reductions.
// synchronous reset loads base 2 and modulus 15; results cannot be stalled.
module convergent_order_candidate_search (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  cocs_pkg::in_item_t               item,
  output logic                             result_valid,
  output cocs_pkg::out_item_t              result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [cocs_pkg::VALUE_WIDTH-1:0] cfg_data
);

  logic [cocs_pkg::VALUE_WIDTH-1:0] base_value, modulus_value;
  cocs_pkg::ctrl_t ctrl;
  cocs_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_value <= cocs_pkg::VALUE_WIDTH'(2);
      modulus_value <= cocs_pkg::VALUE_WIDTH'(15);
    end else if (cfg_valid) begin
      case (cfg_index)
        cocs_pkg::REG_BASE: base_value <= cfg_data;
        cocs_pkg::REG_MODULUS: modulus_value <= cfg_data;
        default: base_value <= base_value;
      endcase
    end
  end

  cocs_controller u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .busy (busy),
    .ctrl (ctrl)
  );

  cocs_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .base_value   (base_value),
    .modulus_value(modulus_value),
    .ctrl         (ctrl),
    .stat         (stat),
    .result       (result)
  );

  assign result_valid = ctrl.done;

endmodule
